// ----- design/clock_setting_editor_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Clock setting editor assertion macros
// Shared property forms for the editor's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CLOCK_SETTING_EDITOR_UNIT_DEFINES_SVH
`define CLOCK_SETTING_EDITOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clock setting editor check failed");

// The consequent must hold in the cycle after the antecedent.
`define CSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clock setting editor check failed");

`endif

// ----- design/cse_pkg.sv -----
// ----------------------------------------------------------------------------
// Clock setting editor package
// Types, codes, range limits and calendar helpers shared by the editor.
// ----------------------------------------------------------------------------
`default_nettype none

package cse_pkg;

  localparam int FIELD_W = 7;
  localparam int CFG_W   = 16;

  localparam logic [FIELD_W-1:0] HOUR_MAX     = 7'd23;
  localparam logic [FIELD_W-1:0] MINSEC_MAX   = 7'd59;
  localparam logic [FIELD_W-1:0] TIME_MIN     = 7'd0;
  localparam logic [FIELD_W-1:0] DAY_MIN      = 7'd1;
  localparam logic [FIELD_W-1:0] MONTH_MIN    = 7'd1;
  localparam logic [FIELD_W-1:0] MONTH_MAX    = 7'd12;
  localparam logic [FIELD_W-1:0] MONTH_FEB    = 7'd2;
  localparam logic [FIELD_W-1:0] YEAR_MIN     = 7'd20;
  localparam logic [FIELD_W-1:0] YEAR_MAX     = 7'd99;
  localparam logic [FIELD_W-1:0] FEB_LEAP     = 7'd29;
  localparam logic [FIELD_W-1:0] FEB_COMMON   = 7'd28;
  localparam logic [FIELD_W-1:0] DAYS_DEFAULT = 7'd31;

  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd10;

  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_NEXT     = 3'd1,
    OP_INC      = 3'd2,
    OP_DEC      = 3'd3,
    OP_HELD_INC = 3'd4,
    OP_HELD_DEC = 3'd5,
    OP_SAVE     = 3'd6,
    OP_LOAD     = 3'd7
  } op_t;

  typedef enum logic [0:0] {
    REG_REPEAT_THRESHOLD = 1'b0,
    REG_DATE_MODE        = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  typedef logic [1:0] sel_t;

  localparam sel_t SEL_FIRST  = 2'd0;
  localparam sel_t SEL_SECOND = 2'd1;
  localparam sel_t SEL_THIRD  = 2'd2;

  typedef struct packed {
    logic [FIELD_W-1:0] first;
    logic [FIELD_W-1:0] second;
    logic [FIELD_W-1:0] third;
  } fields_t;

  // Days in a month; an out-of-range month counts as 31 days.
  function automatic logic [FIELD_W-1:0] month_len(input logic [FIELD_W-1:0] month,
                                                   input logic [FIELD_W-1:0] year);
    logic [3:0] idx;
    idx = month[3:0] - 4'd1;
    if ((month < MONTH_MIN) || (month > MONTH_MAX)) begin
      month_len = DAYS_DEFAULT;
    end else if (month == MONTH_FEB) begin
      month_len = (year[1:0] == 2'b00) ? FEB_LEAP : FEB_COMMON;
    end else begin
      month_len = {2'b00, MONTH_DAYS[idx]};
    end
  endfunction

  // Below the range gives the top, above it gives the bottom.
  function automatic logic [FIELD_W-1:0] wrap_value(input logic signed [FIELD_W+1:0] v,
                                                    input logic [FIELD_W-1:0] lo,
                                                    input logic [FIELD_W-1:0] hi);
    if (v < $signed({2'b00, lo})) begin
      wrap_value = hi;
    end else if (v > $signed({2'b00, hi})) begin
      wrap_value = lo;
    end else begin
      wrap_value = v[FIELD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/clock_setting_editor_unit.sv -----
// ----------------------------------------------------------------------------
// Clock setting editor
// Edits hours/minutes/seconds or day/month/year from button command beats.
// ----------------------------------------------------------------------------
// Each command beat on the s_ side produces exactly one result beat on the
// m_ side carrying the three field values, the selected field and a save flag.
// s_tuser holds the command code; s_tdata holds the repeat tick, the button
// state and the three field values used by a load.
// A beat is registered at the input, then worked through the edit logic into
// the output register, and one beat per cycle is sustained while the receiver
// keeps m_tready high. The edit state updates when a
// beat moves into the output register, so consecutive beats see each other's
// effects. When the receiver stalls, the output register holds its beat and
// the input register can still take one more; s_tready drops only when both
// are full.
// Reset empties both registers, clears the fields, the selection and the
// repeat counter, sets the threshold to 10 and time mode, and arms a load so
// the first beat after reset copies the clock values in.
// Configuration writes on cfg_we take effect at once and are meant for idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "clock_setting_editor_unit_defines.svh"

module clock_setting_editor_unit #(
  parameter int REPEAT_WIDTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // [0] repeat_tick, [1] button_pressed, [8:2] load_first,
  // [15:9] load_second, [22:16] load_third, [23] zero
  input  wire logic [23:0]               s_tdata,
  // [2:0] op
  input  wire logic [2:0]                s_tuser,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // [6:0] first_value, [13:7] second_value, [20:14] third_value,
  // [22:21] selected_field, [23] save_done
  output logic [23:0]                    m_tdata,
  input  wire logic                      cfg_we,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [cse_pkg::CFG_W-1:0] cfg_data
);

  localparam int CMP_W = (REPEAT_WIDTH > cse_pkg::CFG_W) ? REPEAT_WIDTH : cse_pkg::CFG_W;

  // Configuration registers.
  logic [cse_pkg::CFG_W-1:0] repeat_threshold;
  logic                      date_mode;

  // Input register.
  logic             a_valid;
  cse_pkg::op_t     a_op;
  logic             a_tick;
  logic             a_pressed;
  cse_pkg::fields_t a_load;

  // Edit state.
  cse_pkg::fields_t        fields;
  cse_pkg::sel_t           selection;
  logic [REPEAT_WIDTH-1:0] repeat_count;
  logic                    session_start;

  cse_pkg::fields_t        fields_next;
  cse_pkg::sel_t           selection_next;
  logic [REPEAT_WIDTH-1:0] repeat_count_next;
  logic                    session_start_next;
  logic                    save_next;

  cse_pkg::fields_t        edited;
  cse_pkg::step_t          step;
  logic [REPEAT_WIDTH-1:0] count_ticked;
  logic                    held;
  logic                    hit;
  logic                    advance;
  logic                    fire;

  assign advance  = !m_tvalid || m_tready;
  assign fire     = advance && a_valid;
  assign s_tready = !a_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_threshold <= cse_pkg::THRESHOLD_RESET;
      date_mode        <= 1'b0;
    end else if (cfg_we) begin
      case (cse_pkg::reg_index_t'(cfg_index))
        cse_pkg::REG_REPEAT_THRESHOLD: repeat_threshold <= cfg_data;
        cse_pkg::REG_DATE_MODE:        date_mode        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      a_op         <= cse_pkg::op_t'(s_tuser);
      a_tick       <= s_tdata[0];
      a_pressed    <= s_tdata[1];
      a_load.first  <= s_tdata[8:2];
      a_load.second <= s_tdata[15:9];
      a_load.third  <= s_tdata[22:16];
    end
  end

  // The counter compares against the threshold at the wider of the two widths,
  // so a threshold the counter cannot reach never fires.
  assign held         = (a_op == cse_pkg::OP_HELD_INC) || (a_op == cse_pkg::OP_HELD_DEC);
  assign count_ticked = a_tick ? repeat_count + REPEAT_WIDTH'(1) : repeat_count;
  assign hit          = (CMP_W'(count_ticked) == CMP_W'(repeat_threshold));

  always_comb begin
    case (a_op)
      cse_pkg::OP_INC:      step = cse_pkg::STEP_UP;
      cse_pkg::OP_DEC:      step = cse_pkg::STEP_DOWN;
      cse_pkg::OP_HELD_INC: step = hit ? cse_pkg::STEP_UP : cse_pkg::STEP_NONE;
      cse_pkg::OP_HELD_DEC: step = hit ? cse_pkg::STEP_DOWN : cse_pkg::STEP_NONE;
      default:              step = cse_pkg::STEP_NONE;
    endcase
  end

  cse_edit u_edit (
    .cur       (fields),
    .selection (selection),
    .date_mode (date_mode),
    .step      (step),
    .result    (edited)
  );

  always_comb begin
    fields_next        = fields;
    selection_next     = selection;
    repeat_count_next  = repeat_count;
    session_start_next = session_start;
    save_next          = 1'b0;
    if ((a_op == cse_pkg::OP_LOAD) || session_start) begin
      fields_next        = a_load;
      selection_next     = cse_pkg::SEL_FIRST;
      session_start_next = 1'b0;
    end else begin
      case (a_op)
        cse_pkg::OP_NEXT: begin
          selection_next = (selection >= cse_pkg::SEL_THIRD) ? cse_pkg::SEL_FIRST
                                                             : selection + 2'd1;
        end
        cse_pkg::OP_INC, cse_pkg::OP_DEC: begin
          fields_next = edited;
        end
        cse_pkg::OP_HELD_INC, cse_pkg::OP_HELD_DEC: begin
          repeat_count_next = hit ? '0 : count_ticked;
          fields_next       = edited;
        end
        cse_pkg::OP_SAVE: begin
          if (a_pressed) begin
            save_next          = 1'b1;
            session_start_next = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fields        <= '0;
      selection     <= cse_pkg::SEL_FIRST;
      repeat_count  <= '0;
      session_start <= 1'b1;
      m_tvalid      <= 1'b0;
    end else begin
      if (advance) begin
        m_tvalid <= a_valid;
      end
      if (fire) begin
        fields        <= fields_next;
        selection     <= selection_next;
        repeat_count  <= repeat_count_next;
        session_start <= session_start_next;
      end
    end
    if (fire) begin
      m_tdata <= {save_next, selection_next, fields_next.third,
                  fields_next.second, fields_next.first};
    end
  end

  `CSE_ASSERT_SAME(a_sel_range, clk, rst, 1'b1, selection != 2'd3)
  `CSE_ASSERT_SAME(a_stall_full, clk, rst, !s_tready, a_valid && m_tvalid && !m_tready)
  `CSE_ASSERT_NEXT(a_save_rearms, clk, rst, fire && save_next, session_start && m_tdata[23])
  `CSE_ASSERT_NEXT(a_hit_clears, clk, rst, fire && held && hit && !session_start, repeat_count == '0)

endmodule

`default_nettype wire

// ----- design/cse_edit.sv -----
// ----------------------------------------------------------------------------
// Clock setting editor field edit
// Steps the selected field with wrap-around and clamps the day to the month.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_edit (
  input  wire cse_pkg::fields_t cur,
  input  wire cse_pkg::sel_t    selection,
  input  wire logic             date_mode,
  input  wire cse_pkg::step_t   step,
  output cse_pkg::fields_t      result
);

  logic [cse_pkg::FIELD_W-1:0]        sel_val;
  logic signed [cse_pkg::FIELD_W+1:0] stepped;
  logic [cse_pkg::FIELD_W+1:0]        delta;
  logic [cse_pkg::FIELD_W-1:0]        new_month;
  logic [cse_pkg::FIELD_W-1:0]        new_year;
  logic [cse_pkg::FIELD_W-1:0]        len_cur;
  logic [cse_pkg::FIELD_W-1:0]        len_month;
  logic [cse_pkg::FIELD_W-1:0]        len_year;

  always_comb begin
    case (selection)
      cse_pkg::SEL_FIRST:  sel_val = cur.first;
      cse_pkg::SEL_SECOND: sel_val = cur.second;
      default:             sel_val = cur.third;
    endcase

    case (step)
      cse_pkg::STEP_UP:   delta = 9'd1;
      cse_pkg::STEP_DOWN: delta = 9'h1FF;
      default:            delta = 9'd0;
    endcase

    stepped   = $signed({2'b00, sel_val} + delta);
    new_month = cse_pkg::wrap_value(stepped, cse_pkg::MONTH_MIN, cse_pkg::MONTH_MAX);
    new_year  = cse_pkg::wrap_value(stepped, cse_pkg::YEAR_MIN, cse_pkg::YEAR_MAX);
    len_cur   = cse_pkg::month_len(cur.second, cur.third);
    len_month = cse_pkg::month_len(new_month, cur.third);
    len_year  = cse_pkg::month_len(cur.second, new_year);

    result = cur;
    if (!date_mode) begin
      case (selection)
        cse_pkg::SEL_FIRST:
          result.first = cse_pkg::wrap_value(stepped, cse_pkg::TIME_MIN, cse_pkg::HOUR_MAX);
        cse_pkg::SEL_SECOND:
          result.second = cse_pkg::wrap_value(stepped, cse_pkg::TIME_MIN,
                                              cse_pkg::MINSEC_MAX);
        default:
          result.third = cse_pkg::wrap_value(stepped, cse_pkg::TIME_MIN,
                                             cse_pkg::MINSEC_MAX);
      endcase
    end else begin
      case (selection)
        cse_pkg::SEL_FIRST: begin
          result.first = cse_pkg::wrap_value(stepped, cse_pkg::DAY_MIN, len_cur);
        end
        cse_pkg::SEL_SECOND: begin
          result.second = new_month;
          if (cur.first > len_month) begin
            result.first = len_month;
          end
        end
        default: begin
          result.third = new_year;
          // Only February depends on the year.
          if ((cur.second == cse_pkg::MONTH_FEB) && (cur.first > len_year)) begin
            result.first = len_year;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// Clock setting editor testbench
// Drives command beats into the editor and checks every result beat against
// an in-bench model of the field editing, across time and date mode, several
// repeat thresholds, and sender and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  typedef struct {
    cse_pkg::op_t op;
    bit           tick;
    bit           pressed;
    logic [6:0]   ld_first;
    logic [6:0]   ld_second;
    logic [6:0]   ld_third;
  } button_beat_t;

  typedef struct {
    logic [6:0]    first;
    logic [6:0]    second;
    logic [6:0]    third;
    cse_pkg::sel_t sel;
    bit            saved;
  } readout_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata = '0;
  logic [2:0]        s_tuser = cse_pkg::OP_NONE;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [23:0]       m_tdata;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_index = cse_pkg::REG_REPEAT_THRESHOLD;
  logic [cse_pkg::CFG_W-1:0] cfg_data = '0;

  button_beat_t pending_commands[$];
  readout_t     expected_readouts[$];
  button_beat_t beat_on_bus;

  // Editor state as the bench sees it.
  int          fld[3] = '{0, 0, 0};
  int          sel_idx = 0;
  logic [15:0] rpt_count = '0;
  logic [15:0] rpt_limit = cse_pkg::THRESHOLD_RESET;
  bit          date_on = 1'b0;
  bit          session_armed = 1'b1;

  int tx_idle_pct = 16;
  int rx_idle_pct = 83;
  int hold_left = 0;
  bit stall_done = 1'b0;
  int beats_sent = 0;
  int results_seen = 0;
  int errors = 0;

  clock_setting_editor_unit #(.REPEAT_WIDTH(16)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int month_span(int month, int year);
    if (month < 1 || month > 12) return 31;
    case (month)
      2: return (year % 4 == 0) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic int wrap_range(int v, int lo, int hi);
    if (v < lo) return hi;
    if (v > hi) return lo;
    return v;
  endfunction

  function automatic void clamp_day();
    if (fld[0] > month_span(fld[1], fld[2])) fld[0] = month_span(fld[1], fld[2]);
  endfunction

  // Applies one command to the bench state and returns the readout it gives.
  function automatic readout_t clock_edit_step(button_beat_t b);
    readout_t r;
    int delta;
    int v;
    bit saved;
    delta = 0;
    saved = 1'b0;
    if (b.op == cse_pkg::OP_LOAD || session_armed) begin
      fld[0] = int'(b.ld_first);
      fld[1] = int'(b.ld_second);
      fld[2] = int'(b.ld_third);
      sel_idx = 0;
      session_armed = 1'b0;
    end else if (b.op == cse_pkg::OP_NEXT) begin
      sel_idx = (sel_idx >= 2) ? 0 : sel_idx + 1;
    end else if (b.op >= cse_pkg::OP_INC && b.op <= cse_pkg::OP_HELD_DEC) begin
      if (b.op == cse_pkg::OP_INC) begin
        delta = 1;
      end else if (b.op == cse_pkg::OP_DEC) begin
        delta = -1;
      end else begin
        if (b.tick) rpt_count = rpt_count + 16'd1;
        if (rpt_count == rpt_limit) begin
          rpt_count = '0;
          delta = (b.op == cse_pkg::OP_HELD_INC) ? 1 : -1;
        end
      end
      v = fld[sel_idx] + delta;
      if (!date_on) begin
        fld[sel_idx] = wrap_range(v, 0, (sel_idx == 0) ? 23 : 59);
      end else begin
        case (sel_idx)
          0: fld[0] = wrap_range(v, 1, month_span(fld[1], fld[2]));
          1: begin
            fld[1] = wrap_range(v, 1, 12);
            clamp_day();
          end
          default: begin
            fld[2] = wrap_range(v, 20, 99);
            if (fld[1] == 2) clamp_day();
          end
        endcase
      end
    end else if (b.op == cse_pkg::OP_SAVE && b.pressed) begin
      saved = 1'b1;
      session_armed = 1'b1;
    end
    r.first = 7'(fld[0]);
    r.second = 7'(fld[1]);
    r.third = 7'(fld[2]);
    r.sel = cse_pkg::sel_t'(sel_idx);
    r.saved = saved;
    return r;
  endfunction

  function automatic button_beat_t command_beat(cse_pkg::op_t op, bit tick, bit pressed,
                                                int a, int b, int c);
    button_beat_t cb;
    cb.op = op;
    cb.tick = tick;
    cb.pressed = pressed;
    cb.ld_first = 7'(a);
    cb.ld_second = 7'(b);
    cb.ld_third = 7'(c);
    return cb;
  endfunction

  // Mostly plausible clock values, sometimes any value from 0 to 99.
  function automatic button_beat_t random_load_beat(bit date);
    button_beat_t cb;
    cb.op = cse_pkg::OP_LOAD;
    cb.tick = ($urandom_range(99) < 60);
    cb.pressed = 1'($urandom_range(1));
    if ($urandom_range(4) == 0) begin
      cb.ld_first = 7'($urandom_range(99));
      cb.ld_second = 7'($urandom_range(99));
      cb.ld_third = 7'($urandom_range(99));
    end else if (date) begin
      cb.ld_first = 7'($urandom_range(31, 1));
      cb.ld_second = 7'($urandom_range(12, 1));
      cb.ld_third = 7'($urandom_range(99, 20));
    end else begin
      cb.ld_first = 7'($urandom_range(23));
      cb.ld_second = 7'($urandom_range(59));
      cb.ld_third = 7'($urandom_range(59));
    end
    return cb;
  endfunction

  function automatic button_beat_t random_edit_beat(bit date);
    button_beat_t cb;
    int pick;
    cb = random_load_beat(date);
    pick = $urandom_range(99);
    if (pick < 15) cb.op = cse_pkg::OP_NEXT;
    else if (pick < 30) cb.op = cse_pkg::OP_INC;
    else if (pick < 45) cb.op = cse_pkg::OP_DEC;
    else if (pick < 65) cb.op = cse_pkg::OP_HELD_INC;
    else if (pick < 85) cb.op = cse_pkg::OP_HELD_DEC;
    else if (pick < 91) cb.op = cse_pkg::OP_SAVE;
    else if (pick < 96) cb.op = cse_pkg::OP_NONE;
    return cb;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at result %0d: %s", results_seen, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic write_setting(input cse_pkg::reg_index_t idx, input logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == cse_pkg::REG_REPEAT_THRESHOLD) rpt_limit = value;
    else date_on = value[0];
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    while (pending_commands.size() != 0 || s_tvalid || expected_readouts.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Sender: one beat per handshake, the model advanced as each beat is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_readouts.push_back(clock_edit_step(beat_on_bus));
        beats_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_commands.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          beat_on_bus = pending_commands.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= beat_on_bus.op;
          s_tdata <= {1'b0, beat_on_bus.ld_third, beat_on_bus.ld_second,
                      beat_on_bus.ld_first, beat_on_bus.pressed, beat_on_bus.tick};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat and throttles m_tready.
  always @(posedge clk) begin
    readout_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_readouts.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_readouts.pop_front();
          check_field("first_value", int'(m_tdata[6:0]), int'(want.first));
          check_field("second_value", int'(m_tdata[13:7]), int'(want.second));
          check_field("third_value", int'(m_tdata[20:14]), int'(want.third));
          check_field("selected_field", int'(m_tdata[22:21]), int'(want.sel));
          check_field("save_done", int'(m_tdata[23]), int'(want.saved));
        end
        results_seen++;
      end
      // One long hold-off so the two internal registers fill and s_tready drops.
      if (hold_left == 0 && !stall_done && results_seen >= 470) begin
        hold_left = 160;
        stall_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int phase_limit[6] = '{3, 65535, 1, 2, 10, 4};
    bit phase_date[6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    int ph;
    int half;
    int k;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Time mode at reset settings: first beat loads, wraps, bad loads, saves.
    @(negedge clk);
    pending_commands.push_back(command_beat(cse_pkg::OP_NONE, 0, 0, 23, 59, 59));
    pending_commands.push_back(command_beat(cse_pkg::OP_INC, 0, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_DEC, 0, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_NEXT, 0, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_INC, 0, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_NEXT, 0, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_INC, 0, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_LOAD, 0, 0, 99, 99, 99));
    pending_commands.push_back(command_beat(cse_pkg::OP_HELD_INC, 0, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_SAVE, 1, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_SAVE, 1, 1, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_DEC, 1, 1, 5, 6, 7));
    wait_until_drained();

    // Date mode with a one-tick threshold: month and leap-year clamps,
    // an out-of-range month and the year wrap.
    write_setting(cse_pkg::REG_REPEAT_THRESHOLD, 16'd1);
    write_setting(cse_pkg::REG_DATE_MODE, 16'd1);
    @(negedge clk);
    pending_commands.push_back(command_beat(cse_pkg::OP_LOAD, 0, 0, 31, 1, 23));
    pending_commands.push_back(command_beat(cse_pkg::OP_NEXT, 0, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_INC, 0, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_DEC, 0, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_DEC, 0, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_LOAD, 0, 0, 29, 2, 24));
    pending_commands.push_back(command_beat(cse_pkg::OP_NEXT, 0, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_NEXT, 0, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_HELD_INC, 1, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_LOAD, 0, 0, 31, 0, 99));
    pending_commands.push_back(command_beat(cse_pkg::OP_INC, 0, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_NEXT, 0, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_NEXT, 0, 0, 0, 0, 0));
    pending_commands.push_back(command_beat(cse_pkg::OP_INC, 0, 0, 0, 0, 0));
    wait_until_drained();

    for (ph = 0; ph < 6; ph++) begin
      write_setting(cse_pkg::REG_REPEAT_THRESHOLD, 16'(phase_limit[ph]));
      write_setting(cse_pkg::REG_DATE_MODE, 16'(phase_date[ph]));
      @(negedge clk);
      if (ph < 2) begin
        tx_idle_pct = 16;
        rx_idle_pct = 83;
      end else if (ph < 4) begin
        tx_idle_pct = 83;
        rx_idle_pct = 16;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // Each half opens with a load and then edits inside that session;
      // the sender goes quiet between halves until everything is back.
      for (half = 0; half < 2; half++) begin
        pending_commands.push_back(random_load_beat(phase_date[ph]));
        for (k = 1; k < 50; k++) pending_commands.push_back(random_edit_beat(phase_date[ph]));
        wait_until_drained();
      end
    end

    repeat (8) @(posedge clk);
    $display("Ran %0d command beats and checked %0d result beats in time and date mode,",
             beats_sent, results_seen);
    $display("thresholds 1 to 65535, wraps, day clamps, saves, reloads and a long stall.");
    if (errors == 0) begin
      $display("[clock_setting_editor_unit] OK");
    end else begin
      $display("[clock_setting_editor_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[clock_setting_editor_unit] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ----- clock_setting_editor_unit.f -----
+incdir+design
design/cse_pkg.sv
design/cse_edit.sv
design/clock_setting_editor_unit.sv
sim/tb.sv
